[hdl/max_heap_priority_queue_top_macros.svh]
// ---------------------------------------------------------------------------
// Max-heap priority queue assertion macros
// Shared concurrent assertion forms for the priority queue modules.
// ---------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPQ_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MPQ_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/mpq_pkg.sv]
// ---------------------------------------------------------------------------
// Max-heap priority queue package
// Operation and status codes, field widths and the result record.
// ---------------------------------------------------------------------------
package mpq_pkg;

	localparam int DATA_W  = 32;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 9;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
	localparam logic [OP_W-1:0] OP_EXTRACT = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	// One finished result word.
	typedef struct packed {
		logic [COUNT_W-1:0] entry_count;
		logic [STAT_W-1:0]  status;
		logic [DATA_W-1:0]  max_value;
	} mpq_res_t;

endpackage

[hdl/max_heap_priority_queue_top.sv]
// Clear, an unused code and a rejected word go straight to the result word; insert sifts the
// new value up one level at a time; extract returns the root and, unless it was the last
// entry, moves the last entry to the root and sifts it down one level at a time.
// Throughput: one word at a time; the next word is accepted, at the earliest, in the cycle
// after the result is written, and a finished result waits while the output register is still held.
// Reset: the entry count clears at once; heap contents stay undefined, no clearing pass.
// ---------------------------------------------------------------------------
// Max-heap priority queue top level
// Stream wrapper holding the heap memory, the sequencer and the output register.
// ---------------------------------------------------------------------------
module max_heap_priority_queue_top import mpq_pkg::*; #(
	parameter int CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] max_value, [40:32] entry_count, upper zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic              slot_free;
	logic              done;
	mpq_res_t          res;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;
	logic              out_valid_q;
	mpq_res_t          out_res_q;

	assign slot_free = !out_valid_q || m_tready;

	mpq_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_op     (s_tuser),
		.in_value  (s_tdata[DATA_W-1:0]),
		.in_ready  (s_tready),
		.slot_free (slot_free),
		.done      (done),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	mpq_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload.
	always_ff @(posedge clk) begin
		if (done) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_res_q.entry_count, out_res_q.max_value};
	assign m_tuser  = out_res_q.status;

endmodule

[hdl/mpq_ram.sv]
// ---------------------------------------------------------------------------
// Heap storage
// Single write port, single read port memory with registered read data.
// ---------------------------------------------------------------------------
module mpq_ram import mpq_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hdl/mpq_ctrl.sv]
// ---------------------------------------------------------------------------
// Heap sequencer
// Runs insert (sift up), extract (sift down) and clear over the heap memory
// with one shared signed comparator.
// ---------------------------------------------------------------------------
`include "max_heap_priority_queue_top_macros.svh"

module mpq_ctrl import mpq_pkg::*; #(
	parameter int CAPACITY = 256,
	parameter int AW       = 8,
	parameter int CW       = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [OP_W-1:0]   in_op,
	input  logic [DATA_W-1:0] in_value,
	output logic              in_ready,
	input  logic              slot_free,
	output logic              done,
	output mpq_res_t          res,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [DATA_W-1:0] mem_wdata,
	output logic [AW-1:0]     mem_raddr,
	input  logic [DATA_W-1:0] mem_rdata
);

	localparam int IW = AW + 1;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_UP_RD   = 4'd1;
	localparam logic [3:0] ST_UP_CMP  = 4'd2;
	localparam logic [3:0] ST_EX_TOP  = 4'd3;
	localparam logic [3:0] ST_EX_LAST = 4'd4;
	localparam logic [3:0] ST_DN_L    = 4'd5;
	localparam logic [3:0] ST_DN_R    = 4'd6;
	localparam logic [3:0] ST_DN_RC   = 4'd7;
	localparam logic [3:0] ST_DN_MV   = 4'd8;
	localparam logic [3:0] ST_FIN     = 4'd9;

	logic [3:0]        state_q;
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     pos_q;
	logic [AW-1:0]     bidx_q;
	logic [DATA_W-1:0] mov_q;
	logic [DATA_W-1:0] best_q;
	logic [DATA_W-1:0] res_val_q;
	logic [STAT_W-1:0] res_st_q;

	logic [AW-1:0]     par;
	logic [IW-1:0]     lidx;
	logic [IW-1:0]     ridx;
	logic [IW-1:0]     cnt_ext;
	logic [DATA_W-1:0] cmp_a;
	logic [DATA_W-1:0] cmp_b;
	logic              gt;
	logic              accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign done     = (state_q == ST_FIN) && slot_free;

	// Tree neighbors of the current slot.
	assign par     = (pos_q - AW'(1)) >> 1;
	assign lidx    = {pos_q, 1'b1};
	assign ridx    = lidx + IW'(1);
	assign cnt_ext = IW'(cnt_q);

	// Shared signed comparator: cmp_a strictly greater than cmp_b.
	assign gt = $signed(cmp_a) > $signed(cmp_b);

	// Memory addressing, write data and comparator operand selection.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = mov_q;
		mem_raddr = '0;
		cmp_a     = mov_q;
		cmp_b     = mem_rdata;
		unique case (state_q)
			ST_UP_RD: begin
				mem_raddr = par;
				if (pos_q == '0) begin
					mem_we = 1'b1;
				end
			end
			ST_UP_CMP: begin
				mem_we = 1'b1;
				if (gt) begin
					mem_wdata = mem_rdata;
				end
			end
			ST_EX_TOP: begin
				mem_raddr = AW'(cnt_q - CW'(1));
			end
			ST_DN_L: begin
				if (lidx >= cnt_ext) begin
					mem_we = 1'b1;
				end else begin
					mem_raddr = lidx[AW-1:0];
				end
			end
			ST_DN_R: begin
				mem_raddr = ridx[AW-1:0];
			end
			ST_DN_RC: begin
				cmp_a = mem_rdata;
				cmp_b = best_q;
			end
			ST_DN_MV: begin
				cmp_a  = best_q;
				cmp_b  = mov_q;
				mem_we = 1'b1;
				if (gt) begin
					mem_wdata = best_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer state and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						priority if (in_op == OP_INSERT) begin
							if (cnt_q >= CW'(CAPACITY)) begin
								state_q <= ST_FIN;
							end else begin
								cnt_q   <= cnt_q + CW'(1);
								state_q <= ST_UP_RD;
							end
						end else if (in_op == OP_EXTRACT) begin
							state_q <= (cnt_q == '0) ? ST_FIN : ST_EX_TOP;
						end else if (in_op == OP_CLEAR) begin
							cnt_q   <= '0;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_UP_RD:   state_q <= (pos_q == '0) ? ST_FIN : ST_UP_CMP;
				ST_UP_CMP:  state_q <= gt ? ST_UP_RD : ST_FIN;
				ST_EX_TOP: begin
					cnt_q   <= cnt_q - CW'(1);
					state_q <= (cnt_q == CW'(1)) ? ST_FIN : ST_EX_LAST;
				end
				ST_EX_LAST: state_q <= ST_DN_L;
				ST_DN_L:    state_q <= (lidx >= cnt_ext) ? ST_FIN : ST_DN_R;
				ST_DN_R:    state_q <= (ridx < cnt_ext) ? ST_DN_RC : ST_DN_MV;
				ST_DN_RC:   state_q <= ST_DN_MV;
				ST_DN_MV:   state_q <= gt ? ST_DN_L : ST_FIN;
				ST_FIN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers: moving entry, slot position, best child, result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_val_q <= '0;
					res_st_q  <= STAT_OK;
					mov_q     <= in_value;
					pos_q     <= AW'(cnt_q);
					if (in_op == OP_INSERT && cnt_q >= CW'(CAPACITY)) begin
						res_st_q <= STAT_FULL;
					end
					if (in_op == OP_EXTRACT && cnt_q == '0) begin
						res_st_q <= STAT_EMPTY;
					end
				end
			end
			ST_UP_CMP: begin
				if (gt) begin
					pos_q <= par;
				end
			end
			ST_EX_TOP: begin
				res_val_q <= mem_rdata;
			end
			ST_EX_LAST: begin
				mov_q <= mem_rdata;
				pos_q <= '0;
			end
			ST_DN_R: begin
				best_q <= mem_rdata;
				bidx_q <= lidx[AW-1:0];
			end
			ST_DN_RC: begin
				if (gt) begin
					best_q <= mem_rdata;
					bidx_q <= ridx[AW-1:0];
				end
			end
			ST_DN_MV: begin
				if (gt) begin
					pos_q <= bidx_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.max_value   = res_val_q;
	assign res.status      = res_st_q;
	assign res.entry_count = COUNT_W'(cnt_q);

	// The count never passes the capacity.
	`MPQ_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CW'(CAPACITY), "count above capacity")
	// Every write lands inside the live part of the heap.
	`MPQ_ASSERT_IMP(a_wr_live, clk, arst_n, mem_we, IW'(mem_waddr) < cnt_ext, "write beyond count")
	// An empty-heap result reports a count of zero.
	`MPQ_ASSERT_IMP(a_empty_cnt, clk, arst_n, done && res_st_q == STAT_EMPTY, cnt_q == '0,
		"empty status with entries")
	// Handing over a result returns the sequencer to idle.
	`MPQ_ASSERT_NXT(a_done_idle, clk, arst_n, done, state_q == ST_IDLE, "no return to idle")

endmodule
